// ===== hdl/bmm_pkg.sv =====
// Shared constants, types and helper functions for the batched matrix multiplier.
package bmm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int ELEM_BITS = 16;
  localparam int MAX_BATCH = 16;

  // Fixed port field widths
  localparam int VALUE_W    = 16;
  localparam int SUM_W      = 40;
  localparam int ROW_W      = 3;
  localparam int COL_W      = 3;
  localparam int BIDX_W     = 4;
  localparam int DIMCFG_W   = 4;
  localparam int BATCHCFG_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Derived widths
  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int BATCH_W = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int BCNT_W  = $clog2(MAX_BATCH + 1);
  localparam int PROD_W  = 2 * ELEM_BITS;
  localparam int ACC_W   = PROD_W + CNT_W;
  localparam int SAT_W   = (ACC_W > SUM_W) ? ACC_W : SUM_W;
  localparam int A_DEPTH = MAX_DIM * MAX_DIM;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH = 2'd3;

  typedef logic signed [ELEM_BITS-1:0] elem_t;
  typedef logic signed [ACC_W-1:0]     acc_t;
  typedef logic signed [SUM_W-1:0]     sum_t;

  // Token handed from cell to cell: one A element and its position in the row
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] k;
    elem_t            a;
  } tok_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  function automatic sum_t sat_sum(input acc_t v);
    logic signed [SAT_W-1:0] wide;
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    wide = SAT_W'(v);
    hi   = SAT_W'(SUM_MAX);
    lo   = SAT_W'(SUM_MIN);
    if (wide > hi) begin
      return SUM_MAX;
    end else if (wide < lo) begin
      return SUM_MIN;
    end
    return wide[SUM_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] clamp_dim(input logic [DIMCFG_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (v > MAX_DIM) begin
      return CNT_W'(MAX_DIM);
    end
    return CNT_W'(v);
  endfunction

  function automatic logic [BCNT_W-1:0] clamp_batch(input logic [BATCHCFG_W-1:0] v);
    if (v == '0) begin
      return BCNT_W'(1);
    end else if (v > MAX_BATCH) begin
      return BCNT_W'(MAX_BATCH);
    end
    return BCNT_W'(v);
  endfunction

endpackage

// ===== hdl/bmm_if.sv =====
// Stream interfaces: element input channel and product output channel.
interface bmm_elem_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bmm_pkg::VALUE_W-1:0]   element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

interface bmm_prod_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bmm_pkg::SUM_W-1:0]     product_value;
  logic [bmm_pkg::ROW_W-1:0]            result_row;
  logic [bmm_pkg::COL_W-1:0]            result_col;
  logic [bmm_pkg::BIDX_W-1:0]           batch_index;
  logic                                 last_of_matrix;

  modport source (output valid, output product_value, output result_row, output result_col,
                  output batch_index, output last_of_matrix, input ready);
  modport sink   (input valid, input product_value, input result_row, input result_col,
                  input batch_index, input last_of_matrix, output ready);
endinterface

// ===== hdl/bmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bmm_cell.sv =====
// One MAC cell: holds one column of B, accumulates one product element per row.
module bmm_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  bmm_pkg::tok_t                 tok_in,
  output bmm_pkg::tok_t                 tok_out,
  input  logic                          b_we,
  input  logic [bmm_pkg::IDX_W-1:0]     b_row,
  input  bmm_pkg::elem_t                b_data,
  input  logic                          shift,
  input  bmm_pkg::acc_t                 res_in,
  output bmm_pkg::acc_t                 res_out
);

  bmm_pkg::elem_t                    b_mem [bmm_pkg::MAX_DIM];
  bmm_pkg::tok_t                     tok_q;
  bmm_pkg::tok_t                     tok_p;
  logic signed [bmm_pkg::PROD_W-1:0] prod;
  bmm_pkg::acc_t                     acc;
  bmm_pkg::acc_t                     acc_next;
  bmm_pkg::acc_t                     res;

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_row] <= b_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q <= '0;
      tok_p <= '0;
    end else begin
      tok_q <= tok_in;
      tok_p <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    prod <= bmm_pkg::PROD_W'(tok_in.a) * bmm_pkg::PROD_W'(b_mem[tok_in.k]);
  end

  assign acc_next = tok_p.first ? bmm_pkg::ACC_W'(prod) : acc + bmm_pkg::ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (tok_p.valid) begin
      acc <= acc_next;
    end
    // Result chain shifts toward cell 0 during readout
    if (shift) begin
      res <= res_in;
    end else if (tok_p.valid && tok_p.last) begin
      res <= acc_next;
    end
  end

  assign tok_out = tok_q;
  assign res_out = res;

endmodule

// ===== hdl/batched_matrix_multiply_top.sv =====
// Batched matrix multiplier: A RAM, a chain of MAC cells and the load/issue/readout sequencer.
// Loading takes one element word per cycle; ready is low while a product is computed.
// Each product row is issued into the MAC chain and drained until its last token leaves the
// final cell, then read out one word per column.
// Synchronous reset clears the sequencer, batch index and registers (8, 8, 8, 1);
// matrix storage is not cleared and is always written before it is read.
module batched_matrix_multiply_top (
  input  logic                                clk,
  input  logic                                rst,
  bmm_elem_if.sink                            elements,
  bmm_prod_if.source                          products,
  input  logic                                cfg_we,
  input  logic [bmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bmm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int RAM_AW = (bmm_pkg::A_DEPTH > 1) ? $clog2(bmm_pkg::A_DEPTH) : 1;
  localparam int IW = bmm_pkg::IDX_W;
  localparam int CW = bmm_pkg::CNT_W;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [bmm_pkg::DIMCFG_W-1:0]   row_cfg;
  logic [bmm_pkg::DIMCFG_W-1:0]   inner_cfg;
  logic [bmm_pkg::DIMCFG_W-1:0]   col_cfg;
  logic [bmm_pkg::BATCHCFG_W-1:0] batch_cfg;
  logic [CW-1:0]                  rows;
  logic [CW-1:0]                  inner;
  logic [CW-1:0]                  cols;
  logic [bmm_pkg::BCNT_W-1:0]     batches;

  logic [1:0]                     state;
  logic                           phase_b;
  logic [IW-1:0]                  ld_major;
  logic [IW-1:0]                  ld_minor;
  logic [IW-1:0]                  r_cnt;
  logic [IW-1:0]                  k_cnt;
  logic [IW-1:0]                  c_cnt;
  logic [bmm_pkg::BATCH_W-1:0]    batch;

  logic                           head_valid;
  logic                           head_first;
  logic                           head_last;
  logic [IW-1:0]                  head_k;
  logic [bmm_pkg::ELEM_BITS-1:0]  a_rdata;

  logic                           in_fire;
  logic                           out_free;
  logic                           shift;
  bmm_pkg::elem_t                 elem;
  logic [RAM_AW-1:0]              a_waddr;
  logic [RAM_AW-1:0]              a_raddr;

  bmm_pkg::tok_t                  cell_tok_in  [bmm_pkg::MAX_DIM];
  bmm_pkg::tok_t                  cell_tok_out [bmm_pkg::MAX_DIM];
  bmm_pkg::acc_t                  cell_res_in  [bmm_pkg::MAX_DIM];
  bmm_pkg::acc_t                  cell_res_out [bmm_pkg::MAX_DIM];

  logic                           out_valid;
  bmm_pkg::sum_t                  out_value;
  logic [bmm_pkg::ROW_W-1:0]      out_row;
  logic [bmm_pkg::COL_W-1:0]      out_col;
  logic [bmm_pkg::BIDX_W-1:0]     out_batch;
  logic                           out_last;

  logic                           a_minor_last;
  logic                           a_major_last;
  logic                           b_minor_last;
  logic                           b_major_last;
  logic                           k_last;
  logic                           r_last;
  logic                           c_last;
  logic                           batch_wrap;

  assign rows    = bmm_pkg::clamp_dim(row_cfg);
  assign inner   = bmm_pkg::clamp_dim(inner_cfg);
  assign cols    = bmm_pkg::clamp_dim(col_cfg);
  assign batches = bmm_pkg::clamp_batch(batch_cfg);

  assign elements.ready = (state == ST_LOAD);
  assign in_fire  = elements.valid && (state == ST_LOAD);
  assign elem     = elements.element_value[bmm_pkg::ELEM_BITS-1:0];
  assign out_free = !out_valid || products.ready;
  assign shift    = (state == ST_EMIT) && out_free;

  assign a_minor_last = (CW'(ld_minor) == inner - 1'b1);
  assign a_major_last = (CW'(ld_major) == rows - 1'b1);
  assign b_minor_last = (CW'(ld_minor) == cols - 1'b1);
  assign b_major_last = (CW'(ld_major) == inner - 1'b1);
  assign k_last       = (CW'(k_cnt) == inner - 1'b1);
  assign r_last       = (CW'(r_cnt) == rows - 1'b1);
  assign c_last       = (CW'(c_cnt) == cols - 1'b1);
  assign batch_wrap   = (bmm_pkg::BCNT_W'(batch) + 1'b1 >= batches);

  assign a_waddr = RAM_AW'(ld_major * bmm_pkg::MAX_DIM + ld_minor);
  assign a_raddr = RAM_AW'(r_cnt * bmm_pkg::MAX_DIM + k_cnt);

  bmm_ram #(
    .WIDTH (bmm_pkg::ELEM_BITS),
    .DEPTH (bmm_pkg::A_DEPTH)
  ) u_a_ram (
    .clk   (clk),
    .we    (in_fire && !phase_b),
    .waddr (a_waddr),
    .wdata (elem),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // Head token pairs the registered issue control with the RAM read word
  always_comb begin
    cell_tok_in[0].valid = head_valid;
    cell_tok_in[0].first = head_first;
    cell_tok_in[0].last  = head_last;
    cell_tok_in[0].k     = head_k;
    cell_tok_in[0].a     = a_rdata;
  end

  genvar gi;
  generate
    for (gi = 0; gi < bmm_pkg::MAX_DIM; gi++) begin : g_cell
      if (gi > 0) begin : g_link
        assign cell_tok_in[gi] = cell_tok_out[gi-1];
      end
      if (gi < bmm_pkg::MAX_DIM - 1) begin : g_res
        assign cell_res_in[gi] = cell_res_out[gi+1];
      end else begin : g_res_end
        assign cell_res_in[gi] = '0;
      end

      bmm_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (cell_tok_in[gi]),
        .tok_out (cell_tok_out[gi]),
        .b_we    (in_fire && phase_b && (ld_minor == IW'(gi))),
        .b_row   (ld_major),
        .b_data  (elem),
        .shift   (shift),
        .res_in  (cell_res_in[gi]),
        .res_out (cell_res_out[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cfg    <= bmm_pkg::DIMCFG_W'(8);
      inner_cfg  <= bmm_pkg::DIMCFG_W'(8);
      col_cfg    <= bmm_pkg::DIMCFG_W'(8);
      batch_cfg  <= bmm_pkg::BATCHCFG_W'(1);
      state      <= ST_LOAD;
      phase_b    <= 1'b0;
      ld_major   <= '0;
      ld_minor   <= '0;
      r_cnt      <= '0;
      k_cnt      <= '0;
      c_cnt      <= '0;
      batch      <= '0;
      head_valid <= 1'b0;
    end else begin
      head_valid <= (state == ST_ISSUE);

      unique case (state)
        ST_LOAD: begin
          if (in_fire) begin
            if (!phase_b) begin
              if (a_minor_last) begin
                ld_minor <= '0;
                if (a_major_last) begin
                  phase_b  <= 1'b1;
                  ld_major <= '0;
                end else begin
                  ld_major <= ld_major + 1'b1;
                end
              end else begin
                ld_minor <= ld_minor + 1'b1;
              end
            end else begin
              if (b_minor_last) begin
                ld_minor <= '0;
                if (b_major_last) begin
                  phase_b  <= 1'b0;
                  ld_major <= '0;
                  r_cnt    <= '0;
                  k_cnt    <= '0;
                  state    <= ST_ISSUE;
                end else begin
                  ld_major <= ld_major + 1'b1;
                end
              end else begin
                ld_minor <= ld_minor + 1'b1;
              end
            end
          end
        end
        ST_ISSUE: begin
          head_first <= (k_cnt == '0);
          head_last  <= k_last;
          head_k     <= k_cnt;
          if (k_last) begin
            k_cnt <= '0;
            state <= ST_DRAIN;
          end else begin
            k_cnt <= k_cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          // Row is done once the final token has left the end of the chain
          if (cell_tok_out[bmm_pkg::MAX_DIM-1].valid && cell_tok_out[bmm_pkg::MAX_DIM-1].last) begin
            c_cnt <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (c_last) begin
              c_cnt <= '0;
              if (r_last) begin
                r_cnt <= '0;
                state <= ST_LOAD;
                batch <= batch_wrap ? '0 : batch + 1'b1;
              end else begin
                r_cnt <= r_cnt + 1'b1;
                state <= ST_ISSUE;
              end
            end else begin
              c_cnt <= c_cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase

      if (cfg_we) begin
        unique case (cfg_index)
          bmm_pkg::REG_ROWS:  row_cfg   <= cfg_data[bmm_pkg::DIMCFG_W-1:0];
          bmm_pkg::REG_INNER: inner_cfg <= cfg_data[bmm_pkg::DIMCFG_W-1:0];
          bmm_pkg::REG_COLS:  col_cfg   <= cfg_data[bmm_pkg::DIMCFG_W-1:0];
          bmm_pkg::REG_BATCH: batch_cfg <= cfg_data[bmm_pkg::BATCHCFG_W-1:0];
        endcase
        phase_b  <= 1'b0;
        ld_major <= '0;
        ld_minor <= '0;
        batch    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (shift) begin
      out_valid <= 1'b1;
    end else if (products.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (shift) begin
      out_value <= bmm_pkg::sat_sum(cell_res_out[0]);
      out_row   <= bmm_pkg::ROW_W'(r_cnt);
      out_col   <= bmm_pkg::COL_W'(c_cnt);
      out_batch <= bmm_pkg::BIDX_W'(batch);
      out_last  <= r_last && c_last;
    end
  end

  assign products.valid          = out_valid;
  assign products.product_value  = out_value;
  assign products.result_row     = out_row;
  assign products.result_col     = out_col;
  assign products.batch_index    = out_batch;
  assign products.last_of_matrix = out_last;

endmodule

// ===== bench/tb_batched_matrix_multiply_top.sv =====
// Self-checking testbench for the batched matrix multiplier: directed rows, two fixed settings, then random phases.
`timescale 1ns / 1ps

module tb_batched_matrix_multiply_top;

  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int HOLD_AT       = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int REPORT_MAX    = 10;
  localparam int RANDOM_ITEMS  = 180;

  typedef struct packed {
    bmm_pkg::sum_t                 value;
    logic [bmm_pkg::ROW_W-1:0]     row;
    logic [bmm_pkg::COL_W-1:0]     col;
    logic [bmm_pkg::BIDX_W-1:0]    batch;
    logic                          last;
  } product_word_t;

  typedef enum logic {ROW_CFG, ROW_ELEM} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [bmm_pkg::CFG_IDX_W-1:0]  idx;
    logic [bmm_pkg::CFG_DATA_W-1:0] data;
    bmm_pkg::elem_t                 value;
    logic                           fixed;
    product_word_t                  word;
  } stim_row_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [bmm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bmm_pkg::CFG_DATA_W-1:0] cfg_data;

  bmm_elem_if elem_ch();
  bmm_prod_if prod_ch();

  batched_matrix_multiply_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .elements  (elem_ch),
    .products  (prod_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of the block: registers, matrix stores, load position, batch index
  logic [bmm_pkg::DIMCFG_W-1:0]   rows_reg;
  logic [bmm_pkg::DIMCFG_W-1:0]   inner_reg;
  logic [bmm_pkg::DIMCFG_W-1:0]   cols_reg;
  logic [bmm_pkg::BATCHCFG_W-1:0] batches_reg;
  bmm_pkg::elem_t                 a_store [bmm_pkg::A_DEPTH];
  bmm_pkg::elem_t                 b_store [bmm_pkg::A_DEPTH];
  int                             load_pos;
  int                             batch_idx;

  product_word_t pending_products [$];
  product_word_t new_words [$];
  stim_row_t     directed_rows [$];

  int            mismatches = 0;
  int            words_seen = 0;
  int            random_items = 0;
  int            stall_left = 0;
  int            hold_left = 0;
  bit            held_off = 0;
  bit            steady = 0;
  product_word_t seen_word;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int eff_dim(input logic [bmm_pkg::DIMCFG_W-1:0] v);
    if (v == '0) return 1;
    return (v > bmm_pkg::MAX_DIM) ? bmm_pkg::MAX_DIM : int'(v);
  endfunction

  function automatic int eff_batches(input logic [bmm_pkg::BATCHCFG_W-1:0] v);
    if (v == '0) return 1;
    return (v > bmm_pkg::MAX_BATCH) ? bmm_pkg::MAX_BATCH : int'(v);
  endfunction

  function automatic int batch_length();
    return eff_dim(rows_reg) * eff_dim(inner_reg) + eff_dim(inner_reg) * eff_dim(cols_reg);
  endfunction

  function automatic void reset_shadow();
    rows_reg    = 4'd8;
    inner_reg   = 4'd8;
    cols_reg    = 4'd8;
    batches_reg = 5'd1;
    load_pos    = 0;
    batch_idx   = 0;
    foreach (a_store[i]) begin
      a_store[i] = '0;
      b_store[i] = '0;
    end
  endfunction

  function automatic void set_register(input logic [bmm_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [bmm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      bmm_pkg::REG_ROWS:  rows_reg    = data[bmm_pkg::DIMCFG_W-1:0];
      bmm_pkg::REG_INNER: inner_reg   = data[bmm_pkg::DIMCFG_W-1:0];
      bmm_pkg::REG_COLS:  cols_reg    = data[bmm_pkg::DIMCFG_W-1:0];
      bmm_pkg::REG_BATCH: batches_reg = data;
      default: ;
    endcase
    load_pos  = 0;
    batch_idx = 0;
  endfunction

  // stores one element; on the last B word of a batch fills new_words with the product
  function automatic void load_and_multiply(input bmm_pkg::elem_t v);
    int            rows;
    int            inner;
    int            cols;
    int            a_len;
    int            total;
    int            pos;
    longint        acc;
    product_word_t w;
    rows  = eff_dim(rows_reg);
    inner = eff_dim(inner_reg);
    cols  = eff_dim(cols_reg);
    a_len = rows * inner;
    total = batch_length();
    new_words.delete();
    pos = load_pos;
    if (pos >= total) pos = 0;
    if (pos < a_len) a_store[(pos / inner) * bmm_pkg::MAX_DIM + pos % inner] = v;
    else b_store[((pos - a_len) / cols) * bmm_pkg::MAX_DIM + (pos - a_len) % cols] = v;
    pos++;
    if (pos < total) begin
      load_pos = pos;
      return;
    end
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        acc = 0;
        for (int k = 0; k < inner; k++)
          acc += longint'(a_store[r * bmm_pkg::MAX_DIM + k]) *
                 longint'(b_store[k * bmm_pkg::MAX_DIM + c]);
        if (acc > bmm_pkg::SUM_MAX) acc = bmm_pkg::SUM_MAX;
        if (acc < bmm_pkg::SUM_MIN) acc = bmm_pkg::SUM_MIN;
        w.value = bmm_pkg::sum_t'(acc);
        w.row   = bmm_pkg::ROW_W'(r);
        w.col   = bmm_pkg::COL_W'(c);
        w.batch = bmm_pkg::BIDX_W'(batch_idx);
        w.last  = (r + 1 == rows) && (c + 1 == cols);
        new_words.push_back(w);
      end
    end
    load_pos  = 0;
    batch_idx = (batch_idx + 1 >= eff_batches(batches_reg)) ? 0 : batch_idx + 1;
  endfunction

  function automatic void report_mismatch(input string what, input product_word_t want,
                                          input product_word_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch (%s): expected %0d r%0d c%0d b%0d last %0b, %s",
               what, want.value, want.row, want.col, want.batch, want.last,
               $sformatf("got %0d r%0d c%0d b%0d last %0b",
                         got.value, got.row, got.col, got.batch, got.last));
  endfunction

  function automatic void check_word(input product_word_t got);
    product_word_t want;
    if (pending_products.size() == 0) begin
      report_mismatch("nothing expected", '0, got);
      return;
    end
    want = pending_products.pop_front();
    if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
        got.batch !== want.batch || got.last !== want.last)
      report_mismatch("product word", want, got);
  endfunction

  // mostly no gap, some short, a few long
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bmm_pkg::elem_t pick_value();
    case ($urandom_range(0, 11))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return '1;
      default: return bmm_pkg::elem_t'($urandom);
    endcase
  endfunction

  // product side: check, then decide ready; one long hold-off while elements keep coming
  always @(posedge clk) begin
    if (prod_ch.valid && prod_ch.ready) begin
      seen_word.value = prod_ch.product_value;
      seen_word.row   = prod_ch.result_row;
      seen_word.col   = prod_ch.result_col;
      seen_word.batch = prod_ch.batch_index;
      seen_word.last  = prod_ch.last_of_matrix;
      check_word(seen_word);
      words_seen++;
      stall_left = ((words_seen / 40) % 3 == 1) ? 0 : draw_gap();
    end
    if (!held_off && words_seen >= HOLD_AT) begin
      held_off  = 1;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      prod_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      prod_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      prod_ch.ready <= 1'b0;
    end else begin
      prod_ch.ready <= 1'b1;
    end
  end

  // valid stays high across back-to-back words; only a gap (or quiesce) lowers it
  task automatic send_elem(input bmm_pkg::elem_t v, input logic fixed,
                           input product_word_t word);
    int gap;
    gap = steady ? 0 : draw_gap();
    if (gap > 0) begin
      elem_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    elem_ch.valid         <= 1'b1;
    elem_ch.element_value <= v;
    do @(posedge clk); while (!elem_ch.ready);
    load_and_multiply(v);
    if (fixed) pending_products.push_back(word);
    else foreach (new_words[i]) pending_products.push_back(new_words[i]);
  endtask

  task automatic send_random(input int count);
    repeat (count) begin
      send_elem(pick_value(), 1'b0, '0);
      random_items++;
    end
  endtask

  task automatic quiesce();
    int n;
    elem_ch.valid <= 1'b0;
    n = 0;
    while (pending_products.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bmm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bmm_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    set_register(idx, data);
  endtask

  task automatic apply_setting(input logic [bmm_pkg::CFG_DATA_W-1:0] r,
                               input logic [bmm_pkg::CFG_DATA_W-1:0] i,
                               input logic [bmm_pkg::CFG_DATA_W-1:0] c,
                               input logic [bmm_pkg::CFG_DATA_W-1:0] b);
    quiesce();
    write_reg(bmm_pkg::REG_ROWS, r);
    write_reg(bmm_pkg::REG_INNER, i);
    write_reg(bmm_pkg::REG_COLS, c);
    write_reg(bmm_pkg::REG_BATCH, b);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase();
    logic [bmm_pkg::CFG_DATA_W-1:0] dims [3];
    int                             total;
    for (int d = 0; d < 3; d++) begin
      if ($urandom_range(0, 9) < 7) dims[d] = bmm_pkg::CFG_DATA_W'($urandom_range(1, 3));
      else dims[d] = bmm_pkg::CFG_DATA_W'($urandom_range(0, 15));
      dims[d][4] = 1'($urandom_range(0, 1));
    end
    apply_setting(dims[0], dims[1], dims[2], bmm_pkg::CFG_DATA_W'($urandom_range(0, 31)));
    steady = ($urandom_range(0, 3) == 0);
    total  = batch_length();
    send_random(total * ((total > 40) ? 1 : $urandom_range(1, 4)));
    // broken tail: a partial batch that the next write abandons
    if (total > 1 && $urandom_range(0, 4) == 0) send_random($urandom_range(1, total - 1));
  endtask

  function automatic stim_row_t cfg_row(input logic [bmm_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [bmm_pkg::CFG_DATA_W-1:0] data);
    stim_row_t s;
    s      = '0;
    s.kind = ROW_CFG;
    s.idx  = idx;
    s.data = data;
    return s;
  endfunction

  function automatic stim_row_t elem_row(input bmm_pkg::elem_t v);
    stim_row_t s;
    s       = '0;
    s.kind  = ROW_ELEM;
    s.value = v;
    return s;
  endfunction

  // 1x1x1 products: a single word at row 0, col 0, last set
  function automatic stim_row_t checked_row(input bmm_pkg::elem_t v,
                                            input bmm_pkg::sum_t value,
                                            input logic [bmm_pkg::BIDX_W-1:0] batch);
    stim_row_t s;
    s            = elem_row(v);
    s.fixed      = 1'b1;
    s.word.value = value;
    s.word.batch = batch;
    s.word.last  = 1'b1;
    return s;
  endfunction

  initial begin : stimulus
    stim_row_t row;
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_data              <= '0;
    elem_ch.valid         <= 1'b0;
    elem_ch.element_value <= '0;
    reset_shadow();

    // zero dimension clamps to one and 17 truncates to one; batch count 2 alternates the index
    directed_rows.push_back(cfg_row(bmm_pkg::REG_ROWS, 5'd0));
    directed_rows.push_back(cfg_row(bmm_pkg::REG_INNER, 5'd1));
    directed_rows.push_back(cfg_row(bmm_pkg::REG_COLS, 5'd17));
    directed_rows.push_back(cfg_row(bmm_pkg::REG_BATCH, 5'd2));
    directed_rows.push_back(elem_row(16'sh7fff));
    directed_rows.push_back(checked_row(16'sh7fff, 40'sd1073676289, 4'd0));
    directed_rows.push_back(elem_row(16'sh8000));
    directed_rows.push_back(checked_row(16'sh8000, 40'sd1073741824, 4'd1));
    directed_rows.push_back(elem_row(16'sh8000));
    directed_rows.push_back(checked_row(16'sh7fff, -40'sd1073709056, 4'd0));
    directed_rows.push_back(elem_row(16'sh0000));
    directed_rows.push_back(checked_row(16'shffff, 40'sd0, 4'd1));
    // outer product 2x1 by 1x2
    directed_rows.push_back(cfg_row(bmm_pkg::REG_BATCH, 5'd0));
    directed_rows.push_back(cfg_row(bmm_pkg::REG_ROWS, 5'd2));
    directed_rows.push_back(cfg_row(bmm_pkg::REG_COLS, 5'd2));
    directed_rows.push_back(elem_row(16'sd3));
    directed_rows.push_back(elem_row(-16'sd5));
    directed_rows.push_back(elem_row(16'sd7));
    directed_rows.push_back(elem_row(-16'sd11));
    // partly loaded batch, dropped by the following writes
    directed_rows.push_back(cfg_row(bmm_pkg::REG_ROWS, 5'd15));
    directed_rows.push_back(elem_row(16'sd100));
    directed_rows.push_back(elem_row(-16'sd100));
    // one row against eight columns, batch count above the limit
    directed_rows.push_back(cfg_row(bmm_pkg::REG_ROWS, 5'd1));
    directed_rows.push_back(cfg_row(bmm_pkg::REG_INNER, 5'd0));
    directed_rows.push_back(cfg_row(bmm_pkg::REG_COLS, 5'd9));
    directed_rows.push_back(cfg_row(bmm_pkg::REG_BATCH, 5'd31));
    directed_rows.push_back(elem_row(16'sh7fff));
    directed_rows.push_back(elem_row(16'sh8000));
    directed_rows.push_back(elem_row(16'sh7fff));
    directed_rows.push_back(elem_row(16'shffff));
    directed_rows.push_back(elem_row(16'sd1));
    directed_rows.push_back(elem_row(16'sd0));
    directed_rows.push_back(elem_row(16'sd12345));
    directed_rows.push_back(elem_row(-16'sd12345));
    directed_rows.push_back(elem_row(16'sd255));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        if (!cfg_we) quiesce();
        write_reg(row.idx, row.data);
      end else begin
        if (cfg_we) cfg_we <= 1'b0;
        send_elem(row.value, row.fixed, row.word);
      end
    end

    // 1x1x1 with batch count saturated to the maximum: index wraps after 15;
    // the product side holds off partway through while elements keep coming
    apply_setting(5'd1, 5'd16, 5'd1, bmm_pkg::CFG_DATA_W'($urandom_range(16, 31)));
    send_random(2 * (bmm_pkg::MAX_BATCH + 2));
    // largest product
    apply_setting(5'd8, 5'd12, 5'd31, 5'd1);
    send_random(batch_length());
    while (random_items < RANDOM_ITEMS) random_phase();

    quiesce();
    if (mismatches == 0 && pending_products.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
